// File: hw/rtl/rsi_pkg.sv
// Package: shared types and constants for the ray/sphere intersection block
`default_nettype none
package rsi_pkg;

   // root width of the square root and the width of the quarter discriminant
   localparam int ROOT_W  = 51;
   localparam int Q_W     = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 1;
   localparam int H_W     = 51;
   localparam int CELL_COUNT = ROOT_W;

   // configuration register indexes
   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   localparam logic [30:0] RADIUS_RESET = 31'd65536;

   // hit codes
   localparam logic [1:0] HIT_NONE    = 2'd0;
   localparam logic [1:0] HIT_TANGENT = 2'd1;
   localparam logic [1:0] HIT_TWO     = 2'd2;

   typedef struct packed {
      logic signed [31:0] ray_origin_x;
      logic signed [31:0] ray_origin_y;
      logic signed [31:0] ray_origin_z;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
      logic signed [15:0] ray_dir_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         hit_count;
      logic signed [31:0] near_param;
      logic signed [31:0] far_param;
   } rsp_type;

   // data handed from cell to cell along the square root chain
   typedef struct packed {
      logic                  valid;
      logic [1:0]            hit;
      logic signed [H_W-1:0] h;
      logic [Q_W-1:0]        q;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } cell_type;

endpackage
`default_nettype wire

// File: hw/rtl/rsi_prep.sv
// Front pipeline: offset, dot products and the quarter discriminant
`default_nettype none
module rsi_prep
   import rsi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire req_type            in_data,
   input  wire logic signed [31:0] center_x,
   input  wire logic signed [31:0] center_y,
   input  wire logic signed [31:0] center_z,
   input  wire logic [30:0]        radius,
   output cell_type                out_cell
);

   logic [6:0] vld_ff;

   logic signed [32:0] tx_ff, ty_ff, tz_ff;
   logic signed [15:0] dx_ff, dy_ff, dz_ff;
   logic signed [48:0] px_ff, py_ff, pz_ff;
   logic [65:0]        sx_ff, sy_ff, sz_ff;
   logic [61:0]        r2_ff, r2b_ff, r2c_ff;
   logic signed [H_W-1:0] h3_ff, h4_ff, h5_ff, h6_ff;
   logic [66:0]        tt3_ff, tt4_ff;
   logic [49:0]        ah_ff;
   logic [49:0]        p11_ff, p10_ff, p00_ff;
   logic [100:0]       ah2_ff, tt28_ff, r28_ff, pos_ff, neg_ff;
   cell_type           cell_ff;

   logic [32:0]  ax_in, ay_in, az_in;
   logic signed [H_W-1:0] h_in;
   logic [Q_W-1:0] d_in;

   always_comb begin
      ax_in = tx_ff[32] ? 33'(-tx_ff) : 33'(tx_ff);
      ay_in = ty_ff[32] ? 33'(-ty_ff) : 33'(ty_ff);
      az_in = tz_ff[32] ? 33'(-tz_ff) : 33'(tz_ff);
      h_in  = H_W'(px_ff) + H_W'(py_ff) + H_W'(pz_ff);
      d_in  = {1'b0, pos_ff} - {1'b0, neg_ff};
   end

   // track valid items through the stages; bit 6 marks the cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   // advance the arithmetic stages
   always_ff @(posedge clock) begin
      if (advance) begin
         tx_ff <= 33'(in_data.ray_origin_x) - 33'(center_x);
         ty_ff <= 33'(in_data.ray_origin_y) - 33'(center_y);
         tz_ff <= 33'(in_data.ray_origin_z) - 33'(center_z);
         dx_ff <= in_data.ray_dir_x;
         dy_ff <= in_data.ray_dir_y;
         dz_ff <= in_data.ray_dir_z;

         px_ff <= 49'(dx_ff) * 49'(tx_ff);
         py_ff <= 49'(dy_ff) * 49'(ty_ff);
         pz_ff <= 49'(dz_ff) * 49'(tz_ff);
         sx_ff <= 66'(ax_in) * 66'(ax_in);
         sy_ff <= 66'(ay_in) * 66'(ay_in);
         sz_ff <= 66'(az_in) * 66'(az_in);
         r2_ff <= 62'(radius) * 62'(radius);

         h3_ff  <= h_in;
         tt3_ff <= 67'(sx_ff) + 67'(sy_ff) + 67'(sz_ff);
         ah_ff  <= h_in[H_W-1] ? 50'(-h_in) : 50'(h_in);
         r2b_ff <= r2_ff;

         // split the square of |h| into three partial products
         p11_ff <= 50'(ah_ff[49:25]) * 50'(ah_ff[49:25]);
         p10_ff <= 50'(ah_ff[49:25]) * 50'(ah_ff[24:0]);
         p00_ff <= 50'(ah_ff[24:0]) * 50'(ah_ff[24:0]);
         h4_ff  <= h3_ff;
         tt4_ff <= tt3_ff;
         r2c_ff <= r2b_ff;

         ah2_ff  <= (101'(p11_ff) << 50) + (101'(p10_ff) << 26) + 101'(p00_ff);
         tt28_ff <= 101'(tt4_ff) << 28;
         r28_ff  <= 101'(r2c_ff) << 28;
         h5_ff   <= h4_ff;

         pos_ff <= ah2_ff + r28_ff;
         neg_ff <= tt28_ff;
         h6_ff  <= h5_ff;

         cell_ff.valid <= vld_ff[5];
         cell_ff.h     <= h6_ff;
         cell_ff.q     <= d_in;
         cell_ff.rem   <= '0;
         cell_ff.root  <= '0;
         if (d_in[Q_W-1]) begin
            cell_ff.hit <= HIT_NONE;
         end else if (d_in == '0) begin
            cell_ff.hit <= HIT_TANGENT;
         end else begin
            cell_ff.hit <= HIT_TWO;
         end
      end
   end

   // take the valid flag from the reset valid chain
   always_comb begin
      out_cell       = cell_ff;
      out_cell.valid = vld_ff[6];
   end

endmodule
`default_nettype wire

// File: hw/rtl/rsi_sqrt_cell.sv
// One square root cell: settles one root bit from two radicand bits
`default_nettype none
module rsi_sqrt_cell
   import rsi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire cell_type in_cell,
   output cell_type      out_cell
);

   logic [REM_W+1:0] part_in;
   logic [REM_W+1:0] trial_in;
   cell_type         cell_in;
   cell_type         cell_ff;
   logic             valid_ff;

   // bring in two bits, try to subtract the trial divisor
   always_comb begin
      part_in  = {in_cell.rem, in_cell.q[Q_W-1 -: 2]};
      trial_in = (REM_W+2)'({in_cell.root, 2'b01});
      cell_in  = in_cell;
      cell_in.q = {in_cell.q[Q_W-3:0], 2'b00};
      if (part_in >= trial_in) begin
         cell_in.rem  = REM_W'(part_in - trial_in);
         cell_in.root = {in_cell.root[ROOT_W-2:0], 1'b1};
      end else begin
         cell_in.rem  = REM_W'(part_in);
         cell_in.root = {in_cell.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   always_comb begin
      out_cell       = cell_ff;
      out_cell.valid = valid_ff;
   end

endmodule
`default_nettype wire

// File: hw/rtl/ray_sphere_intersection_top.sv
// Top level: registers, input skid, front pipeline, root chain, result stage
//
// Ray/sphere intersection. One ray per cycle is taken unless stalled, and
// one result per ray comes out after seven front stages (offset, products,
// discriminant), a chain of 51 root cells that settle one root bit each,
// and an output register that truncates and saturates the two parameters.
// The whole pipeline stalls while a result waits on rsp_ready; a one-entry
// skid at the input still takes the ray offered in that cycle. Sphere
// centre and radius are to be written via the csr_ port only while no ray
// is in flight (not enforced); writes to any index are taken when offered.
`default_nettype none
module ray_sphere_intersection_top
   import rsi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        radius_ff;
   logic               skid_full_ff;
   req_type            skid_ff;
   logic               advance;
   logic               pipe_valid;
   req_type            pipe_data;
   logic               out_valid_ff;
   rsp_type            out_ff;
   cell_type           chain [0:CELL_COUNT];
   logic signed [H_W+1:0] near_in, far_in;

   assign csr_ready = 1'b1;

   // hold the sphere registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= '0;
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X: cx_ff     <= csr_data;
            REG_CENTER_Y: cy_ff     <= csr_data;
            REG_CENTER_Z: cz_ff     <= csr_data;
            REG_RADIUS:   radius_ff <= csr_data[30:0];
            default:      ;
         endcase
      end
   end

   // stall everything while a result waits
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !skid_full_ff;
   assign pipe_valid = skid_full_ff || req_valid;
   assign pipe_data  = skid_full_ff ? skid_ff : req_data;

   // park a transfer that arrives during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (advance) begin
         skid_full_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && req_valid && req_ready) begin
         skid_ff <= req_data;
      end
   end

   rsi_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (pipe_valid),
      .in_data  (pipe_data),
      .center_x (cx_ff),
      .center_y (cy_ff),
      .center_z (cz_ff),
      .radius   (radius_ff),
      .out_cell (chain[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      rsi_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   // form -h -/+ root at 2^-30 scale
   always_comb begin
      near_in = -(H_W+2)'(chain[CELL_COUNT].h) - (H_W+2)'({2'b00, chain[CELL_COUNT].root});
      far_in  = -(H_W+2)'(chain[CELL_COUNT].h) + (H_W+2)'({2'b00, chain[CELL_COUNT].root});
   end

   function automatic logic signed [31:0] to_q16(input logic signed [H_W+1:0] x);
      logic signed [H_W+1:0] v;
      v = x >>> 14;
      if (v > (H_W+2)'(32'sh7fffffff)) begin
         to_q16 = 32'sh7fffffff;
      end else if (v < -(H_W+2)'(33'sh080000000)) begin
         to_q16 = 32'sh80000000;
      end else begin
         to_q16 = v[31:0];
      end
   endfunction

   // register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[CELL_COUNT].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.hit_count <= chain[CELL_COUNT].hit;
         if (chain[CELL_COUNT].hit == HIT_NONE) begin
            out_ff.near_param <= '0;
            out_ff.far_param  <= '0;
         end else begin
            out_ff.near_param <= to_q16(near_in);
            out_ff.far_param  <= to_q16(far_in);
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count == HIT_NONE |->
         rsp_data.near_param == 0 && rsp_data.far_param == 0)
      else $error("miss with nonzero parameters");

   a_tangent_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count == HIT_TANGENT |->
         rsp_data.near_param == rsp_data.far_param)
      else $error("tangent with differing parameters");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count == HIT_TWO |->
         rsp_data.near_param <= rsp_data.far_param)
      else $error("near parameter above far parameter");

   a_skid: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !advance |=> skid_full_ff && $stable(skid_ff))
      else $error("parked ray lost during stall");

endmodule
`default_nettype wire
